// ===== hdl/altp_pkg.sv =====
// altp_pkg: types and constants shared by the altitude text parser modules
// no dependencies; compiled first
`default_nettype none

package altp_pkg;

    localparam int AMOUNT_W = 20;
    // longest keyword ("UNLIMITED")
    localparam int KW_MAX   = 9;
    localparam int KW_W     = KW_MAX * 8;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_MASK  = 8'hDF;

    typedef enum logic [1:0] {
        KIND_FL    = 2'd0,
        KIND_AMSL  = 2'd1,
        KIND_AGL   = 2'd2,
        KIND_UNLIM = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] ch;
        logic       last_char;
        logic       upper_limit;
    } t_in_item;

    typedef struct packed {
        logic                valid_res;
        t_kind               altitude_kind;
        logic                in_metres;
        logic [AMOUNT_W-1:0] amount;
        logic                is_upper;
    } t_out_item;

    typedef struct packed {
        logic unit_seen;
        logic type_seen;
        logic value_seen;
    } t_found;

    typedef struct packed {
        logic unlim;
        logic feet;
        logic amsl;
        logic fl;
    } t_mode;

    typedef struct packed {
        logic agl;
        logic agnd;
        logic asfc;
        logic gnd;
        logic sfc;
        logic msl;
        logic amsl;
        logic alt;
        logic fl;
        logic unlim;
        logic unlimited;
        logic unl;
        logic ft;
        logic f;
        logic m;
        logic mt;
    } t_kw_hits;

endpackage

`default_nettype wire

// ===== hdl/altp_in_if.sv =====
// altp_in_if: valid/ready channel carrying one text character per beat
// depends on altp_pkg
`default_nettype none

interface altp_in_if;
    logic               valid;
    logic               ready;
    altp_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/altp_out_if.sv =====
// altp_out_if: valid/ready channel carrying one parse result per beat
// depends on altp_pkg
`default_nettype none

interface altp_out_if;
    logic                valid;
    logic                ready;
    altp_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/altp_kw_match.sv =====
// altp_kw_match: case-insensitive compare of the current word against all keywords
// depends on altp_pkg
`default_nettype none

module altp_kw_match #(
    parameter int LEN_W = 4
) (
    input  wire logic [altp_pkg::KW_W-1:0] i_word,
    input  wire logic [LEN_W-1:0]          i_len,
    output altp_pkg::t_kw_hits             o_hits
);
    import altp_pkg::*;

    logic [KW_W-1:0] folded;

    // keyword literals are right-justified; shift left-aligns the first letter
    function automatic logic hit(input logic [KW_W-1:0] w, input logic [LEN_W-1:0] len,
                                 input logic [KW_W-1:0] kw, input int n);
        logic            ok;
        logic [KW_W-1:0] kwl;
        ok  = (len == LEN_W'(n));
        kwl = kw << (8 * (KW_MAX - n));
        for (int k = 0; k < KW_MAX; k++) begin
            if (k < n && w[8*k +: 8] != kwl[8*(KW_MAX-1-k) +: 8]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    always_comb begin
        for (int k = 0; k < KW_MAX; k++) begin
            if (i_word[8*k +: 8] >= CH_LOWER_A && i_word[8*k +: 8] <= CH_LOWER_Z) begin
                folded[8*k +: 8] = i_word[8*k +: 8] & CASE_MASK;
            end else begin
                folded[8*k +: 8] = i_word[8*k +: 8];
            end
        end
    end

    assign o_hits.agl       = hit(folded, i_len, KW_W'("AGL"), 3);
    assign o_hits.agnd      = hit(folded, i_len, KW_W'("AGND"), 4);
    assign o_hits.asfc      = hit(folded, i_len, KW_W'("ASFC"), 4);
    assign o_hits.gnd       = hit(folded, i_len, KW_W'("GND"), 3);
    assign o_hits.sfc       = hit(folded, i_len, KW_W'("SFC"), 3);
    assign o_hits.msl       = hit(folded, i_len, KW_W'("MSL"), 3);
    assign o_hits.amsl      = hit(folded, i_len, KW_W'("AMSL"), 4);
    assign o_hits.alt       = hit(folded, i_len, KW_W'("ALT"), 3);
    assign o_hits.fl        = hit(folded, i_len, KW_W'("FL"), 2);
    assign o_hits.unlim     = hit(folded, i_len, KW_W'("UNLIM"), 5);
    assign o_hits.unlimited = hit(folded, i_len, KW_W'("UNLIMITED"), 9);
    assign o_hits.unl       = hit(folded, i_len, KW_W'("UNL"), 3);
    assign o_hits.ft        = hit(folded, i_len, KW_W'("FT"), 2);
    assign o_hits.f         = hit(folded, i_len, KW_W'("F"), 1);
    assign o_hits.m         = hit(folded, i_len, KW_W'("M"), 1);
    assign o_hits.mt        = hit(folded, i_len, KW_W'("MT"), 2);

endmodule

`default_nettype wire

// ===== hdl/altp_parse_core.sv =====
// altp_parse_core: tokenizer and parse state, one character per step
// depends on altp_pkg and altp_kw_match
`default_nettype none

module altp_parse_core #(
    parameter int WORD_CHARS = 9,
    parameter int VALUE_BITS = 20
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire altp_pkg::t_in_item  i_item,
    output altp_pkg::t_out_item      o_result
);
    import altp_pkg::*;

    localparam int LEN_W = $clog2(WORD_CHARS + 2);
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

    logic                  r_start, n_start;
    logic                  r_num, n_num;
    logic [7:0]            r_word [WORD_CHARS];
    logic [7:0]            n_word [WORD_CHARS];
    logic [LEN_W-1:0]      r_len, n_len;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [VALUE_BITS-1:0] r_value, n_value;
    t_found                r_found, n_found;
    t_mode                 r_mode, n_mode;
    logic                  r_fail, n_fail;
    logic                  r_done, n_done;

    logic                  is_dig, is_sep, last;
    logic [VALUE_BITS-1:0] acc_step, app_acc, tok_acc, open_acc;
    logic [7:0]            app_word [WORD_CHARS];
    logic [LEN_W-1:0]      app_len, tok_len;
    logic [KW_W-1:0]       tok_vec;
    t_kw_hits              hits;
    t_found                ev_found;
    t_mode                 ev_mode;
    logic [VALUE_BITS-1:0] ev_value;
    logic                  ev_fail;

    function automatic logic [VALUE_BITS-1:0] add_digit(input logic [VALUE_BITS-1:0] acc,
                                                         input logic [7:0] c);
        logic [VALUE_BITS+3:0] prod;
        prod = (VALUE_BITS+4)'({acc, 3'b000}) + (VALUE_BITS+4)'({acc, 1'b0})
             + (VALUE_BITS+4)'(c[3:0]);
        if (prod[VALUE_BITS+3:VALUE_BITS] != '0) begin
            return VALUE_MAX;
        end
        return prod[VALUE_BITS-1:0];
    endfunction

    assign last     = i_item.last_char;
    assign is_dig   = (i_item.ch >= CH_ZERO) && (i_item.ch <= CH_NINE);
    assign is_sep   = (i_item.ch == CH_SPACE) || (i_item.ch == CH_EQUAL);
    assign acc_step = add_digit(r_acc, i_item.ch);
    assign app_acc  = is_dig ? acc_step : r_acc;
    assign open_acc = is_dig ? VALUE_BITS'(i_item.ch[3:0]) : '0;
    assign app_len  = (r_len <= LEN_W'(WORD_CHARS)) ? r_len + LEN_W'(1) : r_len;

    always_comb begin
        for (int k = 0; k < WORD_CHARS; k++) begin
            app_word[k] = (r_len == LEN_W'(k)) ? i_item.ch : r_word[k];
        end
    end

    // on the last character the token is judged with that character appended
    assign tok_acc = last ? app_acc : r_acc;
    assign tok_len = (last && !r_num) ? app_len : r_len;

    always_comb begin
        for (int k = 0; k < KW_MAX; k++) begin
            tok_vec[8*k +: 8] = last ? app_word[k] : r_word[k];
        end
    end

    altp_kw_match #(
        .LEN_W (LEN_W)
    ) u_kw_match (
        .i_word (tok_vec),
        .i_len  (tok_len),
        .o_hits (hits)
    );

    // token evaluation
    always_comb begin
        ev_found = r_found;
        ev_mode  = r_mode;
        ev_value = r_value;
        ev_fail  = r_fail;
        if (r_num) begin
            if (r_found.value_seen) begin
                ev_fail = 1'b1;
            end else begin
                ev_value            = tok_acc;
                ev_found.value_seen = 1'b1;
            end
        end else if (!r_found.type_seen) begin
            if (r_found.value_seen) begin
                priority if (hits.agl || hits.agnd || hits.asfc || hits.gnd || hits.sfc) begin
                    ev_mode.amsl       = 1'b0;
                    ev_found.type_seen = 1'b1;
                end else if (hits.msl || hits.amsl || hits.alt) begin
                    ev_found.type_seen = 1'b1;
                end else if (!r_found.unit_seen && (hits.ft || hits.f)) begin
                    ev_found.unit_seen = 1'b1;
                end else if (!r_found.unit_seen && (hits.m || hits.mt)) begin
                    ev_mode.feet       = 1'b0;
                    ev_found.unit_seen = 1'b1;
                end else begin
                    ev_found = r_found;
                end
            end else begin
                priority if (hits.fl) begin
                    ev_mode.fl         = 1'b1;
                    ev_found.type_seen = 1'b1;
                end else if (hits.gnd || hits.sfc) begin
                    ev_mode.amsl = 1'b0;
                    ev_found     = '1;
                end else if (hits.msl || hits.amsl) begin
                    ev_found = '1;
                end else if (hits.unlim || hits.unlimited || hits.unl) begin
                    ev_mode.unlim = 1'b1;
                    ev_found      = '1;
                end else begin
                    ev_found = r_found;
                end
            end
        end
    end

    // next state for one character
    always_comb begin
        n_start = r_start;
        n_num   = r_num;
        n_word  = r_word;
        n_len   = r_len;
        n_acc   = r_acc;
        n_value = r_value;
        n_found = r_found;
        n_mode  = r_mode;
        n_fail  = r_fail;
        n_done  = r_done;
        if (!r_fail && !r_done) begin
            if (r_start || (is_dig == r_num && !is_sep && !last)) begin
                if (r_start) begin
                    n_start = 1'b0;
                    n_num   = is_dig;
                    n_acc   = open_acc;
                    n_len   = is_dig ? '0 : LEN_W'(1);
                    if (!is_dig) begin
                        n_word[0] = i_item.ch;
                    end
                end else if (r_num) begin
                    n_acc = app_acc;
                end else begin
                    n_word = app_word;
                    n_len  = app_len;
                end
            end else begin
                n_found = ev_found;
                n_mode  = ev_mode;
                n_value = ev_value;
                n_fail  = ev_fail;
                if (!ev_fail) begin
                    if (ev_found == '1) begin
                        n_done = 1'b1;
                    end else if (is_sep) begin
                        n_start = 1'b1;
                    end else begin
                        n_num = is_dig;
                        n_acc = open_acc;
                        n_len = is_dig ? '0 : LEN_W'(1);
                        if (!is_dig) begin
                            n_word[0] = i_item.ch;
                        end
                    end
                end
            end
        end
    end

    // result built from the state after this character
    always_comb begin
        o_result.valid_res     = n_found.value_seen && !n_fail;
        o_result.altitude_kind = KIND_FL;
        o_result.in_metres     = 1'b0;
        o_result.amount        = '0;
        o_result.is_upper      = i_item.upper_limit;
        if (o_result.valid_res) begin
            o_result.amount = AMOUNT_W'(n_value);
            priority if (n_mode.unlim) begin
                o_result.altitude_kind = KIND_UNLIM;
            end else if (n_mode.fl) begin
                o_result.altitude_kind = KIND_FL;
            end else begin
                o_result.altitude_kind = n_mode.amsl ? KIND_AMSL : KIND_AGL;
                o_result.in_metres     = !n_mode.feet;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && last)) begin
            r_start <= 1'b1;
            r_num   <= 1'b0;
            r_len   <= '0;
            r_acc   <= '0;
            r_value <= '0;
            r_found <= '0;
            r_mode  <= '{unlim: 1'b0, feet: 1'b1, amsl: 1'b1, fl: 1'b0};
            r_fail  <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_step) begin
            r_start <= n_start;
            r_num   <= n_num;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_value <= n_value;
            r_found <= n_found;
            r_mode  <= n_mode;
            r_fail  <= n_fail;
            r_done  <= n_done;
        end
    end

    // word buffer is read only below the current length
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/altitude_text_parser.sv =====
// altitude_text_parser: one character per beat in, one result beat per text out.
// a character is held in register r_s1; its text's result is registered in r_out.
// throughput: one character per cycle; a last character waits while r_out holds a beat.
// reset: synchronous active-low i_rst_n clears all control and parse state; the
// character buffer is not reset. parse state also returns to reset after every last char.
// depends on altp_pkg, altp_in_if, altp_out_if, altp_parse_core
`default_nettype none

module altitude_text_parser #(
    parameter int WORD_CHARS = 9,
    parameter int VALUE_BITS = 20
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    altp_in_if.sink    i_in,
    altp_out_if.source o_out
);
    import altp_pkg::*;

    logic      r_s1_valid;
    t_in_item  r_s1;
    logic      r_out_valid;
    t_out_item r_out;
    logic      out_free, s1_fire, in_fire;
    t_out_item result;

    assign out_free  = !r_out_valid || o_out.ready;
    // a character that produces no result never waits for the output side
    assign s1_fire   = r_s1_valid && (!r_s1.last_char || out_free);
    assign i_in.ready = !r_s1_valid || s1_fire;
    assign in_fire   = i_in.valid && i_in.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    altp_parse_core #(
        .WORD_CHARS (WORD_CHARS),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_fire),
        .i_item   (r_s1),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire && r_s1.last_char) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= i_in.data;
        end
        if (s1_fire && r_s1.last_char) begin
            r_out <= result;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_s1_valid && !r_out_valid)
        else $error("pipeline valid set after reset");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_fire |=> r_s1_valid && $stable(r_s1))
        else $error("input register overwritten before its step");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.valid_res |->
            r_out.altitude_kind == KIND_FL && !r_out.in_metres && r_out.amount == '0)
        else $error("invalid result carries nonzero fields");

    a_metres_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.in_metres |->
            r_out.altitude_kind == KIND_AMSL || r_out.altitude_kind == KIND_AGL)
        else $error("metres flag on a kind without a unit");

    a_result_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1.last_char |-> out_free)
        else $error("result would overwrite a pending beat");

endmodule

`default_nettype wire
